// ----- src/skdf_pkg.sv -----
// Shared types, constants and the control-store program for the scalar Kalman distance filter.
// Depends on nothing; used by skdf_datapath and scalar_kalman_distance_filter.
`timescale 1ns / 1ps

package skdf_pkg;

    // Field and register widths.
    localparam int RAW_W  = 13;
    localparam int OFS_W  = 10;
    localparam int Q_W    = 32;
    localparam int OUT_W  = 14;
    localparam int GAIN_W = 17;
    localparam int PC_W   = 3;
    localparam int CNT_W  = 5;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_OFFSET_MM         = 2'd0;
    localparam logic [1:0] CFG_PROCESS_NOISE     = 2'd1;
    localparam logic [1:0] CFG_MEASUREMENT_NOISE = 2'd2;

    // Reset values.
    localparam logic [OFS_W-1:0] OFFSET_RESET   = '0;
    localparam logic [Q_W-1:0]   NOISE_RESET    = 32'd65536;
    localparam logic [Q_W-1:0]   VARIANCE_RESET = 32'd6553600;

    // Unity gain in Q1.16 and the number of quotient bits minus one.
    localparam logic [GAIN_W:0]  GAIN_ONE  = 18'd65536;
    localparam logic [CNT_W-1:0] DIV_LAST  = 5'd16;

    // Micro-operations that the datapath understands.
    typedef enum logic [2:0] {
        UOP_WAIT = 3'd0,
        UOP_VADD = 3'd1,
        UOP_DEN  = 3'd2,
        UOP_DIV  = 3'd3,
        UOP_MULG = 3'd4,
        UOP_UPE  = 3'd5,
        UOP_UPV  = 3'd6,
        UOP_OUT  = 3'd7
    } t_uop;

    // Jump conditions of a control word.
    typedef enum logic [1:0] {
        COND_NONE       = 2'd0,
        COND_ALWAYS     = 2'd1,
        COND_LOOP       = 2'd2,
        COND_NOT_PRIMED = 2'd3
    } t_cond;

    // One control word.
    typedef struct packed {
        t_uop             uop;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_ctrl;

    // Status the datapath returns to the sequencer.
    typedef struct packed {
        logic primed;
        logic loop_more;
    } t_stat;

    // Step addresses of the program.
    localparam logic [PC_W-1:0] STEP_WAIT = 3'd0;
    localparam logic [PC_W-1:0] STEP_VADD = 3'd1;
    localparam logic [PC_W-1:0] STEP_DEN  = 3'd2;
    localparam logic [PC_W-1:0] STEP_DIV  = 3'd3;
    localparam logic [PC_W-1:0] STEP_MULG = 3'd4;
    localparam logic [PC_W-1:0] STEP_UPE  = 3'd5;
    localparam logic [PC_W-1:0] STEP_UPV  = 3'd6;
    localparam logic [PC_W-1:0] STEP_OUT  = 3'd7;

    // Control store: one word per step.
    function automatic t_ctrl ucode_rom(input logic [PC_W-1:0] pc);
        t_ctrl w;
        case (pc)
            STEP_WAIT: w = '{uop: UOP_WAIT, cond: COND_NOT_PRIMED, target: STEP_OUT};
            STEP_VADD: w = '{uop: UOP_VADD, cond: COND_NONE,       target: STEP_WAIT};
            STEP_DEN:  w = '{uop: UOP_DEN,  cond: COND_NONE,       target: STEP_WAIT};
            STEP_DIV:  w = '{uop: UOP_DIV,  cond: COND_LOOP,       target: STEP_DIV};
            STEP_MULG: w = '{uop: UOP_MULG, cond: COND_NONE,       target: STEP_WAIT};
            STEP_UPE:  w = '{uop: UOP_UPE,  cond: COND_NONE,       target: STEP_WAIT};
            STEP_UPV:  w = '{uop: UOP_UPV,  cond: COND_NONE,       target: STEP_WAIT};
            STEP_OUT:  w = '{uop: UOP_OUT,  cond: COND_ALWAYS,     target: STEP_WAIT};
            default:   w = '{uop: UOP_WAIT, cond: COND_NONE,       target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- src/skdf_datapath.sv -----
// Arithmetic datapath of the scalar Kalman distance filter: filter state, divider and multiplier.
// Depends on skdf_pkg; driven by the control words of scalar_kalman_distance_filter.
`timescale 1ns / 1ps

module skdf_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  skdf_pkg::t_ctrl                 i_ctrl,
    input  logic                            i_go,
    input  logic [skdf_pkg::RAW_W-1:0]      i_raw_distance_mm,
    input  logic signed [skdf_pkg::OFS_W-1:0] i_offset_mm,
    input  logic [skdf_pkg::Q_W-1:0]        i_process_noise,
    input  logic [skdf_pkg::Q_W-1:0]        i_measurement_noise,
    output skdf_pkg::t_stat                 o_stat,
    output logic [skdf_pkg::OUT_W-1:0]      o_result
);

    // Filter state.
    logic signed [31:0] r_est;
    logic [31:0]        r_err;
    logic               r_primed;

    // Working registers of one step.
    logic signed [31:0] r_meas;
    logic [31:0]        r_var;
    logic signed [32:0] r_diff;
    logic [32:0]        r_den;
    logic [33:0]        r_rem;
    logic [skdf_pkg::GAIN_W-1:0] r_quo;
    logic [skdf_pkg::CNT_W-1:0]  r_cnt;
    logic signed [50:0] r_prod;

    logic signed [15:0] meas_mm;
    logic signed [31:0] meas;
    logic [32:0]        var_sum;
    logic [31:0]        var_sat;
    logic               div_ge;
    logic [33:0]        rem_sub;
    logic signed [17:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [50:0] mul_p;
    logic signed [34:0] corr;
    logic signed [35:0] est_sum;
    logic signed [31:0] est_sat;
    logic [skdf_pkg::GAIN_W:0] one_minus_gain;

    // Measurement in Q16.16: the offset-corrected sample always fits 16 signed bits.
    assign meas_mm = $signed({3'b000, i_raw_distance_mm})
                   - $signed({{6{i_offset_mm[skdf_pkg::OFS_W-1]}}, i_offset_mm});
    assign meas = $signed({meas_mm, 16'h0000});

    // Predicted variance, saturating at full scale.
    assign var_sum = {1'b0, r_err} + {1'b0, i_process_noise};
    assign var_sat = var_sum[32] ? '1 : var_sum[31:0];

    // One restoring division step; a zero divisor yields zero gain.
    assign div_ge  = (r_rem >= {1'b0, r_den}) && (r_den != '0);
    assign rem_sub = div_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    // Shared multiplier: gain times innovation, then variance times (1 - gain).
    assign one_minus_gain = skdf_pkg::GAIN_ONE - {1'b0, r_quo};
    always_comb begin
        if (i_ctrl.uop == skdf_pkg::UOP_MULG) begin
            mul_a = $signed({1'b0, r_quo});
            mul_b = r_diff;
        end else begin
            mul_a = $signed(one_minus_gain);
            mul_b = $signed({1'b0, r_var});
        end
    end
    assign mul_p = mul_a * mul_b;

    // Estimate correction rounded toward minus infinity, then saturated.
    assign corr    = r_prod[50:16];
    assign est_sum = {{4{r_est[31]}}, r_est} + {corr[34], corr};
    always_comb begin
        if (est_sum[35:31] == 5'b00000 || est_sum[35:31] == 5'b11111) begin
            est_sat = est_sum[31:0];
        end else if (est_sum[35]) begin
            est_sat = 32'sh8000_0000;
        end else begin
            est_sat = 32'sh7FFF_FFFF;
        end
    end

    // Filter state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est    <= '0;
            r_err    <= skdf_pkg::VARIANCE_RESET;
            r_primed <= 1'b0;
        end else if (i_go) begin
            case (i_ctrl.uop)
                skdf_pkg::UOP_WAIT: begin
                    r_primed <= 1'b1;
                    if (!r_primed) begin
                        r_est <= meas;
                    end
                end
                skdf_pkg::UOP_UPE: r_est <= est_sat;
                skdf_pkg::UOP_UPV: r_err <= r_prod[47:16];
                default: ;
            endcase
        end
    end

    // Working registers; the loop counter only matters inside the divide loop.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            case (i_ctrl.uop)
                skdf_pkg::UOP_WAIT: r_meas <= meas;
                skdf_pkg::UOP_VADD: begin
                    r_var  <= var_sat;
                    r_diff <= {r_meas[31], r_meas} - {r_est[31], r_est};
                end
                skdf_pkg::UOP_DEN: begin
                    r_den <= {1'b0, r_var} + {1'b0, i_measurement_noise};
                    r_rem <= {2'b00, r_var};
                    r_quo <= '0;
                    r_cnt <= skdf_pkg::DIV_LAST;
                end
                skdf_pkg::UOP_DIV: begin
                    r_rem <= {rem_sub[32:0], 1'b0};
                    r_quo <= {r_quo[skdf_pkg::GAIN_W-2:0], div_ge};
                    r_cnt <= r_cnt - 1'b1;
                end
                skdf_pkg::UOP_MULG: r_prod <= mul_p;
                skdf_pkg::UOP_UPE:  r_prod <= mul_p;
                default: ;
            endcase
        end
    end

    assign o_stat.primed    = r_primed;
    assign o_stat.loop_more = (r_cnt != '0);

    // Whole millimetres of the estimate, zero when it is not positive.
    assign o_result = (r_est[31] || r_est == '0) ? '0 : r_est[29:16];

endmodule

// ----- src/scalar_kalman_distance_filter.sv -----
// Top level of the scalar Kalman distance filter: handshakes, configuration registers and sequencer.
// Depends on skdf_pkg and skdf_datapath.
`timescale 1ns / 1ps

// A one-dimensional Kalman filter for range samples. Each input word is a raw distance in mm;
// the configured offset is subtracted, and each input word yields exactly one output word, the
// filtered distance in whole mm with negative estimates clamped to zero. The first sample after
// reset loads the estimate and goes straight to the output step; every later sample runs the whole
// control program, including the 17 steps of the bit-serial gain divider, from acceptance to the
// output register. One item is processed at a time, but the next input word can be taken
// while the previous result still waits in the output register. Configuration writes are
// accepted in any cycle and should be issued only while the filter is idle.
module scalar_kalman_distance_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [skdf_pkg::RAW_W-1:0]       i_raw_distance_mm,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [skdf_pkg::OUT_W-1:0]       o_filtered_distance_mm,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [skdf_pkg::Q_W-1:0]         i_cfg_data
);

    logic [skdf_pkg::PC_W-1:0]  r_pc;
    logic [skdf_pkg::PC_W-1:0]  n_pc;
    logic                       r_out_valid;
    logic [skdf_pkg::OUT_W-1:0] r_out_data;
    logic signed [skdf_pkg::OFS_W-1:0] r_offset_mm;
    logic [skdf_pkg::Q_W-1:0]   r_process_noise;
    logic [skdf_pkg::Q_W-1:0]   r_measurement_noise;

    skdf_pkg::t_ctrl            ctrl;
    skdf_pkg::t_stat            stat;
    logic                       stall;
    logic                       go;
    logic                       jump;
    logic                       out_free;
    logic [skdf_pkg::OUT_W-1:0] result;

    // Fetch the control word of the current step.
    assign ctrl = skdf_pkg::ucode_rom(r_pc);

    // A step waits for an input word or for room in the output register.
    assign out_free = !r_out_valid || i_out_ready;
    assign stall = (ctrl.uop == skdf_pkg::UOP_WAIT && !i_in_valid)
                || (ctrl.uop == skdf_pkg::UOP_OUT && !out_free);
    assign go = !stall;

    // Jump condition of the control word.
    always_comb begin
        case (ctrl.cond)
            skdf_pkg::COND_NONE:       jump = 1'b0;
            skdf_pkg::COND_ALWAYS:     jump = 1'b1;
            skdf_pkg::COND_LOOP:       jump = stat.loop_more;
            skdf_pkg::COND_NOT_PRIMED: jump = !stat.primed;
            default:                   jump = 1'b0;
        endcase
    end

    // Next step address.
    always_comb begin
        if (stall) begin
            n_pc = r_pc;
        end else if (jump) begin
            n_pc = ctrl.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= skdf_pkg::STEP_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    skdf_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctrl              (ctrl),
        .i_go                (go),
        .i_raw_distance_mm   (i_raw_distance_mm),
        .i_offset_mm         (r_offset_mm),
        .i_process_noise     (r_process_noise),
        .i_measurement_noise (r_measurement_noise),
        .o_stat              (stat),
        .o_result            (result)
    );

    // Output register: loaded by the last step, emptied by the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.uop == skdf_pkg::UOP_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.uop == skdf_pkg::UOP_OUT && out_free) begin
            r_out_data <= result;
        end
    end

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_mm         <= skdf_pkg::OFFSET_RESET;
            r_process_noise     <= skdf_pkg::NOISE_RESET;
            r_measurement_noise <= skdf_pkg::NOISE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                skdf_pkg::CFG_OFFSET_MM:
                    r_offset_mm <= i_cfg_data[skdf_pkg::OFS_W-1:0];
                skdf_pkg::CFG_PROCESS_NOISE:
                    r_process_noise <= i_cfg_data;
                skdf_pkg::CFG_MEASUREMENT_NOISE:
                    r_measurement_noise <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready             = (ctrl.uop == skdf_pkg::UOP_WAIT);
    assign o_out_valid            = r_out_valid;
    assign o_filtered_distance_mm = r_out_data;
    assign o_cfg_ready            = 1'b1;

endmodule
